// ===== hdl/matrix3x3_inverse_unit_defines.svh =====
// Assertion macros used by the checker file m3i_checker.sv.
`ifndef MATRIX3X3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3X3_INVERSE_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define M3I_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge.
`define M3I_ASSERT_IMP(label, cond, expr, msg) \
    `M3I_ASSERT(label, (cond) |-> (expr), msg)

`endif

// ===== hdl/m3i_pkg.sv =====
package m3i_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;
    localparam int SHIFT    = 24;              // Q8.8 in, Q16.16 out
    localparam int PW       = 2 * IN_W;        // 2x2 product
    localparam int CW       = 2 * IN_W + 1;    // cofactor
    localparam int DPW      = 3 * IN_W + 1;    // row-1 term of determinant
    localparam int DW       = 3 * IN_W + 3;    // determinant
    localparam int NW       = CW + SHIFT;      // scaled numerator
    localparam int RW       = (NW > DW + OUT_W) ? NW + 1 : DW + OUT_W + 1;
    localparam int FRONT_LAT = 4;
    localparam int DIV_LAT   = OUT_W + 3;
    localparam int LAT       = FRONT_LAT + DIV_LAT + 1;

    typedef struct packed {
        logic signed [IN_W-1:0] in_r1c1;
        logic signed [IN_W-1:0] in_r1c2;
        logic signed [IN_W-1:0] in_r1c3;
        logic signed [IN_W-1:0] in_r2c1;
        logic signed [IN_W-1:0] in_r2c2;
        logic signed [IN_W-1:0] in_r2c3;
        logic signed [IN_W-1:0] in_r3c1;
        logic signed [IN_W-1:0] in_r3c2;
        logic signed [IN_W-1:0] in_r3c3;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_r1c1;
        logic signed [OUT_W-1:0] out_r1c2;
        logic signed [OUT_W-1:0] out_r1c3;
        logic signed [OUT_W-1:0] out_r2c1;
        logic signed [OUT_W-1:0] out_r2c2;
        logic signed [OUT_W-1:0] out_r2c3;
        logic signed [OUT_W-1:0] out_r3c1;
        logic signed [OUT_W-1:0] out_r3c2;
        logic signed [OUT_W-1:0] out_r3c3;
        logic                    singular;
        logic                    saturated;
    } t_out;

endpackage

// ===== hdl/m3i_cof.sv =====
// Cofactors and determinant, four register stages.
module m3i_cof
    import m3i_pkg::*;
(
    input  logic                 i_clk,
    input  t_in                  i_mat,
    output logic signed [CW-1:0] o_cof [9],
    output logic signed [DW-1:0] o_det
);

    logic signed [IN_W-1:0] w_m [9];
    logic signed [PW-1:0]   r_p [18];
    logic signed [IN_W-1:0] r_m0a [3];
    logic signed [IN_W-1:0] r_m0b [3];
    logic signed [CW-1:0]   r_c [9];
    logic signed [CW-1:0]   r_c2 [9];
    logic signed [DPW-1:0]  r_dp [3];
    logic signed [CW-1:0]   r_c3 [9];
    logic signed [DW-1:0]   r_det;

    assign w_m[0] = i_mat.in_r1c1;
    assign w_m[1] = i_mat.in_r1c2;
    assign w_m[2] = i_mat.in_r1c3;
    assign w_m[3] = i_mat.in_r2c1;
    assign w_m[4] = i_mat.in_r2c2;
    assign w_m[5] = i_mat.in_r2c3;
    assign w_m[6] = i_mat.in_r3c1;
    assign w_m[7] = i_mat.in_r3c2;
    assign w_m[8] = i_mat.in_r3c3;

    // stage A: eighteen 2x2 products
    always_ff @(posedge i_clk) begin
        r_p[0]  <= PW'(w_m[4]) * PW'(w_m[8]);
        r_p[1]  <= PW'(w_m[5]) * PW'(w_m[7]);
        r_p[2]  <= PW'(w_m[3]) * PW'(w_m[8]);
        r_p[3]  <= PW'(w_m[5]) * PW'(w_m[6]);
        r_p[4]  <= PW'(w_m[3]) * PW'(w_m[7]);
        r_p[5]  <= PW'(w_m[4]) * PW'(w_m[6]);
        r_p[6]  <= PW'(w_m[1]) * PW'(w_m[8]);
        r_p[7]  <= PW'(w_m[2]) * PW'(w_m[7]);
        r_p[8]  <= PW'(w_m[0]) * PW'(w_m[8]);
        r_p[9]  <= PW'(w_m[2]) * PW'(w_m[6]);
        r_p[10] <= PW'(w_m[0]) * PW'(w_m[7]);
        r_p[11] <= PW'(w_m[1]) * PW'(w_m[6]);
        r_p[12] <= PW'(w_m[1]) * PW'(w_m[5]);
        r_p[13] <= PW'(w_m[2]) * PW'(w_m[4]);
        r_p[14] <= PW'(w_m[0]) * PW'(w_m[5]);
        r_p[15] <= PW'(w_m[2]) * PW'(w_m[3]);
        r_p[16] <= PW'(w_m[0]) * PW'(w_m[4]);
        r_p[17] <= PW'(w_m[1]) * PW'(w_m[3]);
        for (int k = 0; k < 3; k++) begin
            r_m0a[k] <= w_m[k];
        end
    end

    // stage B: signed cofactors; odd positions take the minus sign
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            if (k % 2 == 0) begin
                r_c[k] <= CW'(r_p[2*k]) - CW'(r_p[2*k+1]);
            end else begin
                r_c[k] <= CW'(r_p[2*k+1]) - CW'(r_p[2*k]);
            end
        end
        r_m0b <= r_m0a;
    end

    // stage C: row-1 expansion terms
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dp[k] <= DPW'(r_m0b[k]) * DPW'(r_c[k]);
        end
        r_c2 <= r_c;
    end

    // stage D: determinant
    always_ff @(posedge i_clk) begin
        r_det <= DW'(r_dp[0]) + DW'(r_dp[1]) + DW'(r_dp[2]);
        r_c3  <= r_c2;
    end

    assign o_cof = r_c3;
    assign o_det = r_det;

endmodule

// ===== hdl/m3i_div_lane.sv =====
// Pipelined restoring divider with saturation, one quotient bit per stage.
module m3i_div_lane
    import m3i_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic [OUT_W-1:0]     o_quot,
    output logic                 o_sat
);

    logic [NW-1:0]    r_na;
    logic [DW-1:0]    r_da;
    logic             r_neg0;
    logic [RW-1:0]    r_rem [OUT_W+1];
    logic [DW-1:0]    r_d   [OUT_W+1];
    logic [OUT_W-1:0] r_q   [OUT_W+1];
    logic             r_neg [OUT_W+1];
    logic             r_ovf [OUT_W+1];
    logic [OUT_W-1:0] r_quot;
    logic             r_sat;
    logic             w_big;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        r_na   <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        r_da   <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        r_neg0 <= i_num[NW-1] ^ i_den[DW-1];
    end

    // quotient at or above 2^OUT_W is out of range regardless of sign
    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(r_na);
        r_d[0]   <= r_da;
        r_q[0]   <= '0;
        r_neg[0] <= r_neg0;
        r_ovf[0] <= RW'(r_na) >= (RW'(r_da) << OUT_W);
    end

    for (genvar k = 0; k < OUT_W; k++) begin : g_bit
        localparam int B = OUT_W - 1 - k;
        logic [RW-1:0] w_dsh;
        logic          w_take;
        assign w_dsh  = RW'(r_d[k]) << B;
        assign w_take = r_rem[k] >= w_dsh;
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_take ? r_rem[k] - w_dsh : r_rem[k];
            r_q[k+1]   <= r_q[k] | (OUT_W'(w_take) << B);
            r_d[k+1]   <= r_d[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    // positive limit is 2^(OUT_W-1)-1, negative limit 2^(OUT_W-1)
    assign w_big = r_neg[OUT_W]
                 ? (r_q[OUT_W][OUT_W-1] && (|r_q[OUT_W][OUT_W-2:0]))
                 : r_q[OUT_W][OUT_W-1];

    always_ff @(posedge i_clk) begin
        r_sat <= r_ovf[OUT_W] | w_big;
        if (r_ovf[OUT_W] || w_big) begin
            r_quot <= r_neg[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}}
                                   : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            r_quot <= r_neg[OUT_W] ? OUT_W'(-r_q[OUT_W]) : r_q[OUT_W];
        end
    end

    assign o_quot = r_quot;
    assign o_sat  = r_sat;

endmodule

// ===== hdl/matrix3x3_inverse_unit.sv =====
// 3x3 matrix inverse by the adjugate method. One matrix (nine signed Q8.8
// entries) is taken per clock; start is accepted whenever busy is low, and
// busy never rises, so a new matrix can enter on every cycle. Each result
// (nine signed Q16.16 entries plus singular and saturated flags) appears on
// o_inv for exactly one cycle with o_done high. The nine divider lanes
// resolve one quotient bit per pipeline stage. The receiver cannot
// stall: capture o_inv in the cycle o_done is high.
module matrix3x3_inverse_unit
    import m3i_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_mat,
    output logic o_done,
    output t_out o_inv
);

    logic signed [CW-1:0] w_cof [9];
    logic signed [DW-1:0] w_det;
    logic [OUT_W-1:0]     w_quot [9];
    logic [8:0]           w_sat;
    logic [LAT-1:0]       r_vld;
    logic [DIV_LAT-1:0]   r_sing;
    t_out                 r_out;
    logic [OUT_W-1:0]     w_ent [9];

    // the pipeline never holds off a transfer
    assign busy = 1'b0;

    // cofactors and determinant
    m3i_cof u_cof (
        .i_clk (i_clk),
        .i_mat (i_mat),
        .o_cof (w_cof),
        .o_det (w_det)
    );

    // nine divider lanes; lane (i,j) divides cofactor (j,i), the adjugate
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            logic signed [NW-1:0] w_num;
            assign w_num = {w_cof[j*3+i], {SHIFT{1'b0}}};
            m3i_div_lane u_lane (
                .i_clk  (i_clk),
                .i_num  (w_num),
                .i_den  (w_det),
                .o_quot (w_quot[i*3+j]),
                .o_sat  (w_sat[i*3+j])
            );
        end
    end

    // track which pipeline slots carry a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // carry the zero-determinant flag alongside the divider lanes
    always_ff @(posedge i_clk) begin
        r_sing <= {r_sing[DIV_LAT-2:0], (w_det == '0)};
    end

    // merge: zero every entry of a singular matrix, combine lane flags
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_ent[k] = r_sing[DIV_LAT-1] ? '0 : w_quot[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.out_r1c1  <= w_ent[0];
        r_out.out_r1c2  <= w_ent[1];
        r_out.out_r1c3  <= w_ent[2];
        r_out.out_r2c1  <= w_ent[3];
        r_out.out_r2c2  <= w_ent[4];
        r_out.out_r2c3  <= w_ent[5];
        r_out.out_r3c1  <= w_ent[6];
        r_out.out_r3c2  <= w_ent[7];
        r_out.out_r3c3  <= w_ent[8];
        r_out.singular  <= r_sing[DIV_LAT-1];
        r_out.saturated <= ~r_sing[DIV_LAT-1] & (|w_sat);
    end

    assign o_done = r_vld[LAT-1];
    assign o_inv  = r_out;

endmodule

// ===== hdl/m3i_checker.sv =====
`include "matrix3x3_inverse_unit_defines.svh"

// Port-level checks on the inverse unit.
module m3i_checker
    import m3i_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_out o_inv
);

    `M3I_ASSERT(a_never_busy, !busy, "busy raised")
    `M3I_ASSERT_IMP(a_latency, start, ##LAT o_done, "result strobe missing")
    `M3I_ASSERT_IMP(a_sing_nosat, o_done && o_inv.singular, !o_inv.saturated, "singular and saturated")
    `M3I_ASSERT_IMP(a_sing_zero, o_done && o_inv.singular, o_inv.out_r1c1 == '0 && o_inv.out_r2c2 == '0 && o_inv.out_r3c3 == '0, "singular entries nonzero")

endmodule

bind matrix3x3_inverse_unit m3i_checker u_m3i_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_inv   (o_inv)
);
